// ===== design/iqr_pkg.sv =====
// iqr_pkg: request and record types, record kind codes and fixed limits
// for the iqr outlier detector
// no dependencies
`timescale 1ns / 1ps

package iqr_pkg;

    // record kinds
    localparam logic [1:0] KIND_OUTLIER = 2'd0;
    localparam logic [1:0] KIND_CLEAN   = 2'd1;
    localparam logic [1:0] KIND_SHORT   = 2'd2;

    // fewest kept values for which quartiles are taken
    localparam int MIN_VALUES = 4;
    // most outlier records per column
    localparam int OUT_LIMIT  = 64;

    // one input row
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               is_numeric;
        logic               last_row;
    } t_sample;

    // one result record
    typedef struct packed {
        logic [1:0]         record_kind;
        logic [15:0]        column_number;
        logic [15:0]        row_number;
        logic signed [31:0] outlier_value;
        logic signed [31:0] lower_quartile;
        logic signed [31:0] upper_quartile;
        logic [31:0]        spread;
        logic [6:0]         numeric_count;
        logic               capacity_overflow;
        logic               last_record;
    } t_result;

    // per-cycle command broadcast to every cell of the sort chain
    typedef struct packed {
        logic insert;
        logic rotate;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== design/iqr_cell.sv =====
// iqr_cell: one slot of the sorted insertion chain, holding a value,
// its row and a valid bit; depends on iqr_pkg
`timescale 1ns / 1ps

module iqr_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  iqr_pkg::t_cell_ctl           i_ctl,
    input  logic signed [VALUE_BITS-1:0] i_new_value,
    input  logic [15:0]                  i_new_row,
    input  logic signed [VALUE_BITS-1:0] i_left_value,
    input  logic [15:0]                  i_left_row,
    input  logic                         i_left_valid,
    input  logic                         i_left_gt,
    input  logic signed [VALUE_BITS-1:0] i_right_value,
    input  logic [15:0]                  i_right_row,
    input  logic                         i_right_valid,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic [15:0]                  o_row,
    output logic                         o_valid,
    output logic                         o_gt
);

    logic signed [VALUE_BITS-1:0] r_value;
    logic [15:0]                  r_row;
    logic                         r_valid;
    logic                         w_gt;
    logic                         w_take;

    // strictly greater keeps equal values in arrival order
    assign w_gt   = r_valid && (r_value > i_new_value);
    // shift right when greater, or fill the first empty slot
    assign w_take = w_gt || (!r_valid && i_left_valid);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert && w_take) begin
            r_valid <= 1'b1;
        end else if (i_ctl.rotate) begin
            r_valid <= i_right_valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && w_take) begin
            r_value <= i_left_gt ? i_left_value : i_new_value;
            r_row   <= i_left_gt ? i_left_row   : i_new_row;
        end else if (i_ctl.rotate) begin
            r_value <= i_right_value;
            r_row   <= i_right_row;
        end
    end

    assign o_value = r_value;
    assign o_row   = r_row;
    assign o_valid = r_valid;
    assign o_gt    = w_gt;

endmodule

// ===== design/iqr_outlier_detector.sv =====
// iqr_outlier_detector: top level, sort chain of iqr_cell slots, quartile
// and fence arithmetic, outlier walk and result register; depends on iqr_pkg
`timescale 1ns / 1ps

// Rows of one column come in one request per cycle while in the input state;
// each numeric value is placed into a chain of MAX_VALUES cells that keeps
// values sorted with their row numbers. On the request marked last_row the
// block stops taking requests and finishes the column: the chain rotates
// once around while the quartile entries are picked off the head, the
// S_QUART and S_FENCE states form Q1, Q3, the spread and the Tukey fences,
// and a second walk checks each value at the chain head, up to OUT_LIMIT
// outliers, and emits outliers in ascending order. A final state gives the
// final record and clears the chain; the walk and the final state can wait
// while the consumer stalls the result register. A column with fewer than
// four kept values goes straight to that final state with a single status
// record.

module iqr_outlier_detector #(
    parameter int MAX_VALUES = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  iqr_pkg::t_sample i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output iqr_pkg::t_result o_out_req
);

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int POS_W = $clog2(MAX_VALUES);
    localparam int RAW_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int F_W   = VALUE_BITS + 4;
    localparam int SP_W  = (VALUE_BITS + 1 > 33) ? VALUE_BITS + 1 : 33;
    localparam int CW2   = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_QUART = 3'd2;
    localparam logic [2:0] S_FENCE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // control registers
    logic [2:0]       r_state;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count;
    logic [6:0]       r_k;
    logic             r_pend_valid;
    logic             r_short;
    logic             r_out_valid;
    logic [15:0]      r_row_cnt;
    logic [15:0]      r_col_cnt;
    logic             r_overflow;

    // payload registers
    logic signed [VALUE_BITS-1:0] r_lo1, r_hi1, r_lo3, r_hi3;
    logic signed [VALUE_BITS-1:0] r_q1, r_q3;
    logic signed [VALUE_BITS:0]   r_iqr;
    logic signed [F_W-1:0]        r_lo2, r_hi2;
    logic signed [VALUE_BITS-1:0] r_pend_value;
    logic [15:0]                  r_pend_row;
    iqr_pkg::t_result             r_out;
    iqr_pkg::t_result             n_out;

    // chain wiring
    logic signed [VALUE_BITS-1:0] w_val [MAX_VALUES];
    logic [15:0]                  w_row [MAX_VALUES];
    logic [MAX_VALUES-1:0]        w_valid;
    logic [MAX_VALUES-1:0]        w_gt;
    iqr_pkg::t_cell_ctl           w_ctl;

    logic [RAW_W-1:0]             w_raw;
    logic signed [VALUE_BITS-1:0] w_new_value;
    logic                         w_accept;
    logic                         w_has_room;
    logic                         w_insert;
    logic [CNT_W-1:0]             w_count_after;

    // request decode: low VALUE_BITS bits as two's complement
    assign w_raw         = RAW_W'($unsigned(i_in_req.sample_value));
    assign w_new_value   = $signed(w_raw[VALUE_BITS-1:0]);
    assign o_in_ready    = (r_state == S_IN);
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_has_room    = (r_count < CNT_W'(MAX_VALUES));
    assign w_insert      = w_accept && i_in_req.is_numeric && w_has_room;
    assign w_count_after = w_insert ? r_count + 1'b1 : r_count;

    // quartile entry positions in the sorted order
    logic [CNT_W-1:0] w_half, w_b1, w_a1, w_start, w_a3, w_b3, w_pos_ext;
    assign w_half    = r_count >> 1;
    assign w_b1      = w_half >> 1;
    assign w_a1      = w_half[0] ? w_b1 : w_b1 - 1'b1;
    assign w_start   = w_half + CNT_W'(r_count[0]);
    assign w_a3      = w_start + w_a1;
    assign w_b3      = w_start + w_b1;
    assign w_pos_ext = CNT_W'(r_pos);

    // outlier test on the chain head
    logic signed [F_W-1:0] w_v2;
    logic                  w_head_out;
    logic                  w_out_free;
    logic                  w_stall;
    logic                  w_advance;
    logic                  w_walk_end;
    logic                  w_cap_end;
    logic                  w_push_emit;
    logic                  w_push_fin;

    assign w_v2        = F_W'(w_val[0]) <<< 1;
    assign w_head_out  = (w_v2 < r_lo2) || (w_v2 > r_hi2);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_stall     = w_head_out && r_pend_valid && !w_out_free;
    assign w_advance   = (r_state == S_EMIT) && !w_stall;
    assign w_walk_end  = (w_pos_ext == r_count - 1'b1);
    assign w_cap_end   = w_head_out && (r_k == 7'(iqr_pkg::OUT_LIMIT - 1));
    assign w_push_emit = w_advance && w_head_out && r_pend_valid;
    assign w_push_fin  = (r_state == S_FIN) && w_out_free;

    // chain command
    always_comb begin
        w_ctl.insert = w_insert;
        w_ctl.rotate = (r_state == S_SCAN) || w_advance;
        w_ctl.clear  = w_push_fin;
    end

    // sort chain: head at cell 0, rotation moves toward the head
    for (genvar gi = 0; gi < MAX_VALUES; gi++) begin : g_cell
        localparam int RI = (gi + 1) % MAX_VALUES;
        logic signed [VALUE_BITS-1:0] w_lv;
        logic [15:0]                  w_lr;
        logic                         w_lvalid;
        logic                         w_lgt;
        if (gi == 0) begin : g_head
            assign w_lv     = w_new_value;
            assign w_lr     = r_row_cnt;
            assign w_lvalid = 1'b1;
            assign w_lgt    = 1'b0;
        end else begin : g_body
            assign w_lv     = w_val[gi-1];
            assign w_lr     = w_row[gi-1];
            assign w_lvalid = w_valid[gi-1];
            assign w_lgt    = w_gt[gi-1];
        end
        iqr_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_value  (w_new_value),
            .i_new_row    (r_row_cnt),
            .i_left_value (w_lv),
            .i_left_row   (w_lr),
            .i_left_valid (w_lvalid),
            .i_left_gt    (w_lgt),
            .i_right_value(w_val[RI]),
            .i_right_row  (w_row[RI]),
            .i_right_valid(w_valid[RI]),
            .o_value      (w_val[gi]),
            .o_row        (w_row[gi]),
            .o_valid      (w_valid[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    // quartile and fence arithmetic
    logic signed [VALUE_BITS:0] w_sum1, w_sum3;
    logic signed [VALUE_BITS:0] w_avg1, w_avg3;
    logic signed [VALUE_BITS:0] w_iqr;
    logic signed [F_W-1:0]      w_iqr_f;
    assign w_sum1  = (VALUE_BITS + 1)'(r_lo1) + (VALUE_BITS + 1)'(r_hi1);
    assign w_sum3  = (VALUE_BITS + 1)'(r_lo3) + (VALUE_BITS + 1)'(r_hi3);
    assign w_avg1  = w_sum1 >>> 1;
    assign w_avg3  = w_sum3 >>> 1;
    assign w_iqr   = (VALUE_BITS + 1)'(r_q3) - (VALUE_BITS + 1)'(r_q1);
    assign w_iqr_f = F_W'(w_iqr);

    // record fields: spread for outlier and clean records, count for all kinds
    logic [SP_W-1:0] w_iqr_u;
    logic [31:0]     w_spread;
    logic [CW2-1:0]  w_cnt_ext;
    logic [6:0]      w_cnt_sat;
    assign w_iqr_u   = SP_W'($unsigned(r_iqr));
    assign w_spread  = (w_iqr_u > SP_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : w_iqr_u[31:0];
    assign w_cnt_ext = CW2'(r_count);
    assign w_cnt_sat = (w_cnt_ext > CW2'(127)) ? 7'd127 : w_cnt_ext[6:0];

    // next result record
    always_comb begin
        n_out.record_kind       = iqr_pkg::KIND_OUTLIER;
        n_out.column_number     = r_col_cnt;
        n_out.row_number        = r_pend_row;
        n_out.outlier_value     = 32'(r_pend_value);
        n_out.lower_quartile    = 32'(r_q1);
        n_out.upper_quartile    = 32'(r_q3);
        n_out.spread            = w_spread;
        n_out.numeric_count     = w_cnt_sat;
        n_out.capacity_overflow = r_overflow;
        n_out.last_record       = (r_state == S_FIN);
        if (r_state == S_FIN && r_short) begin
            n_out.record_kind    = iqr_pkg::KIND_SHORT;
            n_out.row_number     = '0;
            n_out.outlier_value  = '0;
            n_out.lower_quartile = '0;
            n_out.upper_quartile = '0;
            n_out.spread         = '0;
        end else if (r_state == S_FIN && !r_pend_valid) begin
            n_out.record_kind   = iqr_pkg::KIND_CLEAN;
            n_out.row_number    = '0;
            n_out.outlier_value = '0;
        end
    end

    // control sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IN;
            r_pos        <= '0;
            r_count      <= '0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_short      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_row_cnt    <= '0;
            r_col_cnt    <= '0;
            r_overflow   <= 1'b0;
        end else begin
            // result register handshake
            if (w_push_emit || w_push_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IN: begin
                    if (w_accept) begin
                        r_count <= w_count_after;
                        if (i_in_req.is_numeric && !w_has_room) begin
                            r_overflow <= 1'b1;
                        end
                        if (i_in_req.last_row) begin
                            r_row_cnt    <= '0;
                            r_pos        <= '0;
                            r_k          <= '0;
                            r_pend_valid <= 1'b0;
                            r_short      <= (w_count_after < CNT_W'(iqr_pkg::MIN_VALUES));
                            r_state      <= (w_count_after < CNT_W'(iqr_pkg::MIN_VALUES))
                                            ? S_FIN : S_SCAN;
                        end else if (r_row_cnt != 16'hFFFF) begin
                            r_row_cnt <= r_row_cnt + 16'd1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pos == POS_W'(MAX_VALUES - 1)) begin
                        r_pos   <= '0;
                        r_state <= S_QUART;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_QUART: begin
                    r_state <= S_FENCE;
                end
                S_FENCE: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_advance) begin
                        r_pos <= r_pos + 1'b1;
                        if (w_head_out) begin
                            r_pend_valid <= 1'b1;
                            r_k          <= r_k + 7'd1;
                        end
                        if (w_walk_end || w_cap_end) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_count      <= '0;
                        r_overflow   <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_short      <= 1'b0;
                        if (r_col_cnt != 16'hFFFF) begin
                            r_col_cnt <= r_col_cnt + 16'd1;
                        end
                        r_state <= S_IN;
                    end
                end
                default: begin
                    r_state <= S_IN;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // pick quartile entries as they pass the head
        if (r_state == S_SCAN) begin
            if (w_pos_ext == w_a1) r_lo1 <= w_val[0];
            if (w_pos_ext == w_b1) r_hi1 <= w_val[0];
            if (w_pos_ext == w_a3) r_lo3 <= w_val[0];
            if (w_pos_ext == w_b3) r_hi3 <= w_val[0];
        end
        // quartiles, floor of the pair average
        if (r_state == S_QUART) begin
            r_q1 <= w_avg1[VALUE_BITS-1:0];
            r_q3 <= w_avg3[VALUE_BITS-1:0];
        end
        // doubled fences: 2*q1 - 3*iqr and 2*q3 + 3*iqr
        if (r_state == S_FENCE) begin
            r_iqr <= w_iqr;
            r_lo2 <= (F_W'(r_q1) <<< 1) - (w_iqr_f + (w_iqr_f <<< 1));
            r_hi2 <= (F_W'(r_q3) <<< 1) + (w_iqr_f + (w_iqr_f <<< 1));
        end
        // hold the newest outlier until the next one shows whether it is last
        if (w_advance && w_head_out) begin
            r_pend_value <= w_val[0];
            r_pend_row   <= w_row[0];
        end
        if (w_push_emit || w_push_fin) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule
